@@ hdl/iss_pkg.sv @@
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and constants of the irrigation schedule sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package iss_pkg;

  localparam int TABLE_SLOTS = 6;
  localparam int SECTORS     = 3;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = 3;

  localparam logic [7:0] SETTLE_RESET = 8'd5;
  localparam logic [5:0] MINUTE_NONE  = 6'd63;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_CANCEL = 2'd3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_VALVE = 2'd1;
  localparam logic [1:0] PH_WATER = 2'd2;
  localparam logic [1:0] PH_DRAIN = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SECT = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BAD_SLOT = 2'd3;

  typedef struct packed {
    logic latch;
    logic exec;
    logic start_run;
    logic report;
  } iss_cmd_t;

  typedef struct packed {
    logic is_tick;
  } iss_stat_t;

endpackage

`default_nettype wire

@@ hdl/irrigation_schedule_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// irrigation_schedule_sequencer_core
// Watering schedule table with a valve/pump run sequencer.
//
//   channel   handshake              fields
//   command   start / busy           op, now_*, entry_*, target_slot
//   result    done (one cycle)       valve_mask .. running
//   config    cfg_we                 cfg_wdata (settle ticks)
//
// A tick goes through capture, execute, run start and report before the done
// beat; other commands skip run start. The six-slot table is compared in
// parallel in the execute cycle. Synchronous reset clears the table and run
// state; no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module irrigation_schedule_sequencer_core (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  output logic       busy,
  output logic       done,
  input  wire        cfg_we,
  input  wire  [7:0] cfg_wdata,
  input  wire  [1:0] op,
  input  wire  [4:0] now_hour,
  input  wire  [5:0] now_minute,
  input  wire  [1:0] entry_sector,
  input  wire  [4:0] entry_hour,
  input  wire  [5:0] entry_minute,
  input  wire  [5:0] entry_duration,
  input  wire  [2:0] target_slot,
  output logic [2:0] valve_mask,
  output logic       pump_on,
  output logic [5:0] minutes_left,
  output logic [1:0] status,
  output logic [2:0] slot_used,
  output logic [2:0] entry_count,
  output logic       running
);
  import iss_pkg::*;

  iss_cmd_t  cmd;
  iss_stat_t stat;

  iss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  iss_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .op             (op),
    .now_hour       (now_hour),
    .now_minute     (now_minute),
    .entry_sector   (entry_sector),
    .entry_hour     (entry_hour),
    .entry_minute   (entry_minute),
    .entry_duration (entry_duration),
    .target_slot    (target_slot),
    .valve_mask     (valve_mask),
    .pump_on        (pump_on),
    .minutes_left   (minutes_left),
    .status         (status),
    .slot_used      (slot_used),
    .entry_count    (entry_count),
    .running        (running)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_done_follows_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a command in flight");

  a_pump_needs_run: assert property (@(posedge clk) disable iff (rst)
    (done && pump_on) |-> (running && valve_mask != 3'd0))
    else $error("pump driven outside a run");

endmodule

`default_nettype wire

@@ hdl/iss_ctrl.sv @@
// ----------------------------------------------------------------------------
// iss_ctrl
// Sequencing state machine: capture, execute, run start, report.
// ----------------------------------------------------------------------------
`default_nettype none

module iss_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  iss_pkg::iss_stat_t stat,
  output iss_pkg::iss_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import iss_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_START = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next    = state;
    cmd.latch     = 1'b0;
    cmd.exec      = 1'b0;
    cmd.start_run = 1'b0;
    cmd.report    = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.is_tick ? S_START : S_DONE;
      end
      S_START: begin
        cmd.start_run = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.report;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

@@ hdl/iss_dp.sv @@
// ----------------------------------------------------------------------------
// iss_dp
// Datapath: entry table, run phase registers and registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module iss_dp (
  input  wire                clk,
  input  wire                rst,
  input  iss_pkg::iss_cmd_t  cmd,
  output iss_pkg::iss_stat_t stat,
  input  wire                cfg_we,
  input  wire  [7:0]         cfg_wdata,
  input  wire  [1:0]         op,
  input  wire  [4:0]         now_hour,
  input  wire  [5:0]         now_minute,
  input  wire  [1:0]         entry_sector,
  input  wire  [4:0]         entry_hour,
  input  wire  [5:0]         entry_minute,
  input  wire  [5:0]         entry_duration,
  input  wire  [2:0]         target_slot,
  output logic [2:0]         valve_mask,
  output logic               pump_on,
  output logic [5:0]         minutes_left,
  output logic [1:0]         status,
  output logic [2:0]         slot_used,
  output logic [2:0]         entry_count,
  output logic               running
);
  import iss_pkg::*;

  // captured command
  logic [1:0] op_r;
  logic [4:0] now_hour_r;
  logic [5:0] now_minute_r;
  logic [1:0] sector_r;
  logic [4:0] hour_r;
  logic [5:0] minute_r;
  logic [5:0] duration_r;
  logic [2:0] target_r;

  // table and run state
  logic [1:0] tab_sector   [TABLE_SLOTS];
  logic [4:0] tab_hour     [TABLE_SLOTS];
  logic [5:0] tab_minute   [TABLE_SLOTS];
  logic [5:0] tab_duration [TABLE_SLOTS];
  logic [CNT_W-1:0]       occupied_count;
  logic [TABLE_SLOTS-1:0] pending_mask;
  logic [1:0]             phase;
  logic [SLOT_W-1:0]      active_slot;
  logic [5:0]             remaining;
  logic [7:0]             settle_left;
  logic [5:0]             last_minute;
  logic [7:0]             settle_ticks;
  logic [1:0]             res_status;
  logic [2:0]             res_slot;

  // execute-stage terms
  logic                   new_min;
  logic [5:0]             rem_a;
  logic [7:0]             set_a;
  logic [1:0]             ph_a;
  logic [TABLE_SLOTS-1:0] match;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;
  logic                   sect_bad;
  logic                   del_bad;
  logic [SLOT_W-1:0]      del_idx;
  logic                   pend_found;
  logic [SLOT_W-1:0]      pend_idx;
  logic [1:0]             act_sector;
  logic [2:0]             valve_next;

  assign stat.is_tick = (op_r == OP_TICK);

  always_comb begin
    new_min = (now_minute_r != last_minute);
    rem_a   = remaining;
    set_a   = settle_left;
    ph_a    = phase;
    if (new_min && (phase == PH_VALVE || phase == PH_WATER) && remaining != 6'd0) begin
      rem_a = remaining - 6'd1;
    end
    case (phase)
      PH_VALVE: begin
        if (settle_left != 8'd0) begin
          set_a = settle_left - 8'd1;
        end
        if (set_a == 8'd0) begin
          ph_a = PH_WATER;
        end
      end
      PH_WATER: begin
        if (rem_a == 6'd0) begin
          ph_a  = PH_DRAIN;
          set_a = settle_ticks;
        end
      end
      PH_DRAIN: begin
        if (settle_left != 8'd0) begin
          set_a = settle_left - 8'd1;
        end
        if (set_a == 8'd0) begin
          ph_a = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    pend_found = 1'b0;
    pend_idx   = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      match[i] = (tab_sector[i] != 2'd0) && (tab_hour[i] == now_hour_r) &&
                 (tab_minute[i] == now_minute_r);
      if (tab_sector[i] == 2'd0) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
      if (pending_mask[i]) begin
        pend_found = 1'b1;
        pend_idx   = SLOT_W'(i);
      end
    end
  end

  assign sect_bad   = (sector_r == 2'd0) || (3'(sector_r) > 3'(SECTORS));
  assign del_idx    = SLOT_W'(target_r);
  assign del_bad    = (4'(target_r) >= 4'(TABLE_SLOTS)) ||
                      ((phase != PH_IDLE) && (4'(target_r) == 4'(active_slot)));
  assign act_sector = tab_sector[active_slot];

  always_comb begin
    valve_next = 3'd0;
    if (phase != PH_IDLE && 4'(active_slot) < 4'(TABLE_SLOTS)) begin
      case (act_sector)
        2'd1:    valve_next = 3'b001;
        2'd2:    valve_next = 3'b010;
        2'd3:    valve_next = 3'b100;
        default: valve_next = 3'b000;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r         <= op;
      now_hour_r   <= now_hour;
      now_minute_r <= now_minute;
      sector_r     <= entry_sector;
      hour_r       <= entry_hour;
      minute_r     <= entry_minute;
      duration_r   <= entry_duration;
      target_r     <= target_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        tab_sector[i]   <= 2'd0;
        tab_hour[i]     <= 5'd0;
        tab_minute[i]   <= 6'd0;
        tab_duration[i] <= 6'd0;
      end
      occupied_count <= '0;
      pending_mask   <= '0;
      phase          <= PH_IDLE;
      active_slot    <= '0;
      remaining      <= 6'd0;
      settle_left    <= 8'd0;
      last_minute    <= MINUTE_NONE;
      settle_ticks   <= SETTLE_RESET;
      res_status     <= ST_OK;
      res_slot       <= 3'd0;
    end else begin
      if (cfg_we) begin
        settle_ticks <= cfg_wdata;
      end
      if (cmd.exec) begin
        case (op_r)
          OP_TICK: begin
            res_status  <= ST_OK;
            res_slot    <= 3'd0;
            last_minute <= now_minute_r;
            phase       <= ph_a;
            remaining   <= rem_a;
            settle_left <= set_a;
            if (new_min) begin
              pending_mask <= pending_mask | match;
            end
          end
          OP_ADD: begin
            if (sect_bad) begin
              res_status <= ST_BAD_SECT;
              res_slot   <= 3'd0;
            end else if (!free_found) begin
              res_status <= ST_FULL;
              res_slot   <= 3'd0;
            end else begin
              tab_sector[free_idx]   <= sector_r;
              tab_hour[free_idx]     <= hour_r;
              tab_minute[free_idx]   <= minute_r;
              tab_duration[free_idx] <= duration_r;
              occupied_count         <= occupied_count + CNT_W'(1);
              res_status             <= ST_OK;
              res_slot               <= 3'(free_idx);
            end
          end
          OP_DELETE: begin
            if (del_bad) begin
              res_status <= ST_BAD_SLOT;
              res_slot   <= 3'd0;
            end else begin
              if (tab_sector[del_idx] != 2'd0) begin
                tab_sector[del_idx]   <= 2'd0;
                tab_hour[del_idx]     <= 5'd0;
                tab_minute[del_idx]   <= 6'd0;
                tab_duration[del_idx] <= 6'd0;
                occupied_count        <= occupied_count - CNT_W'(1);
              end
              pending_mask[del_idx] <= 1'b0;
              res_status            <= ST_OK;
              res_slot              <= target_r;
            end
          end
          OP_CANCEL: begin
            res_status   <= ST_OK;
            res_slot     <= 3'd0;
            pending_mask <= '0;
            phase        <= PH_IDLE;
            remaining    <= 6'd0;
            settle_left  <= 8'd0;
          end
          default: begin
            res_status <= ST_OK;
            res_slot   <= 3'd0;
          end
        endcase
      end
      if (cmd.start_run && phase == PH_IDLE && pend_found) begin
        pending_mask[pend_idx] <= 1'b0;
        active_slot            <= pend_idx;
        remaining              <= tab_duration[pend_idx];
        settle_left            <= settle_ticks;
        phase                  <= PH_VALVE;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      valve_mask   <= valve_next;
      pump_on      <= (phase == PH_WATER);
      minutes_left <= (phase != PH_IDLE) ? remaining : 6'd0;
      status       <= res_status;
      slot_used    <= res_slot;
      entry_count  <= 3'(occupied_count);
      running      <= (phase != PH_IDLE);
    end
  end

endmodule

`default_nettype wire

@@ sim/irrigation_schedule_sequencer_core_tb.sv @@
// ----------------------------------------------------------------------------
// irrigation_schedule_sequencer_core_tb
// Self-checking bench for the irrigation schedule sequencer. Commands go in
// through start/busy. A built-in schedule and run model predicts every done
// beat, and the beats are compared field by field in order. A directed pass
// covers table edges, bad slots and zero-length runs. Random traffic then
// schedules entries a few minutes ahead of a moving wall clock, so runs go
// through all phases at several settle settings.
// ----------------------------------------------------------------------------
`default_nettype none

module irrigation_schedule_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iss_pkg::*;

  localparam int IDLE_LIMIT = 1000;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [1:0] entry_sector;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;
    logic [5:0] entry_duration;
    logic [2:0] target_slot;
  } cmd_t;

  typedef struct packed {
    logic [2:0] valve_mask;
    logic       pump_on;
    logic [5:0] minutes_left;
    logic [1:0] status;
    logic [2:0] slot_used;
    logic [2:0] entry_count;
    logic       running;
  } relay_state_t;

  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       start          = 1'b0;
  logic       cfg_we         = 1'b0;
  logic [7:0] cfg_wdata      = 8'd0;
  logic [1:0] op             = OP_TICK;
  logic [4:0] now_hour       = 5'd0;
  logic [5:0] now_minute     = 6'd0;
  logic [1:0] entry_sector   = 2'd0;
  logic [4:0] entry_hour     = 5'd0;
  logic [5:0] entry_minute   = 6'd0;
  logic [5:0] entry_duration = 6'd0;
  logic [2:0] target_slot    = 3'd0;
  logic       busy;
  logic       done;
  logic [2:0] valve_mask;
  logic       pump_on;
  logic [5:0] minutes_left;
  logic [1:0] status;
  logic [2:0] slot_used;
  logic [2:0] entry_count;
  logic       running;

  // schedule and run state as the block should hold it
  logic [1:0]             sch_sector   [TABLE_SLOTS] = '{default: '0};
  logic [4:0]             sch_hour     [TABLE_SLOTS] = '{default: '0};
  logic [5:0]             sch_minute   [TABLE_SLOTS] = '{default: '0};
  logic [5:0]             sch_duration [TABLE_SLOTS] = '{default: '0};
  logic [2:0]             occ_count    = 3'd0;
  logic [TABLE_SLOTS-1:0] pending_runs = '0;
  logic [1:0]             run_phase    = PH_IDLE;
  logic [2:0]             run_slot     = 3'd0;
  logic [5:0]             run_left     = 6'd0;
  logic [7:0]             settle_cnt   = 8'd0;
  logic [5:0]             prev_minute  = MINUTE_NONE;
  logic [7:0]             settle_cfg   = SETTLE_RESET;

  relay_state_t expected_relays[$];
  int fail_count    = 0;
  int beats_sent    = 0;
  int beats_checked = 0;
  int runs_started  = 0;
  int idle_cycles   = 0;
  int wall_h;
  int wall_m;

  irrigation_schedule_sequencer_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .op             (op),
    .now_hour       (now_hour),
    .now_minute     (now_minute),
    .entry_sector   (entry_sector),
    .entry_hour     (entry_hour),
    .entry_minute   (entry_minute),
    .entry_duration (entry_duration),
    .target_slot    (target_slot),
    .valve_mask     (valve_mask),
    .pump_on        (pump_on),
    .minutes_left   (minutes_left),
    .status         (status),
    .slot_used      (slot_used),
    .entry_count    (entry_count),
    .running        (running)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic predict_relays(input cmd_t c, output relay_state_t r);
    logic       new_min;
    logic       found;
    logic [1:0] st;
    logic [2:0] slot;
    int         i;
    st   = ST_OK;
    slot = 3'd0;
    found = 1'b0;
    case (c.op)
      OP_TICK: begin
        new_min     = (c.now_minute != prev_minute);
        prev_minute = c.now_minute;
        if (new_min && (run_phase == PH_VALVE || run_phase == PH_WATER) && run_left != 0)
          run_left = run_left - 6'd1;
        case (run_phase)
          PH_VALVE, PH_DRAIN: begin
            if (settle_cnt != 0) settle_cnt = settle_cnt - 8'd1;
            if (settle_cnt == 0) run_phase = (run_phase == PH_VALVE) ? PH_WATER : PH_IDLE;
          end
          PH_WATER: begin
            if (run_left == 0) begin
              run_phase  = PH_DRAIN;
              settle_cnt = settle_cfg;
            end
          end
          default: ;
        endcase
        if (new_min) begin
          for (i = 0; i < TABLE_SLOTS; i++)
            if (sch_sector[i] != 0 && sch_hour[i] == c.now_hour &&
                sch_minute[i] == c.now_minute)
              pending_runs[i] = 1'b1;
        end
        if (run_phase == PH_IDLE && pending_runs != 0) begin
          for (i = 0; i < TABLE_SLOTS; i++) begin
            if (!found && pending_runs[i]) begin
              found           = 1'b1;
              pending_runs[i] = 1'b0;
              run_slot        = 3'(i);
              run_left        = sch_duration[i];
              settle_cnt      = settle_cfg;
              run_phase       = PH_VALVE;
              runs_started++;
            end
          end
        end
      end
      OP_ADD: begin
        if (c.entry_sector == 0 || c.entry_sector > SECTORS) begin
          st = ST_BAD_SECT;
        end else begin
          st = ST_FULL;
          for (i = 0; i < TABLE_SLOTS; i++) begin
            if (!found && sch_sector[i] == 0) begin
              found           = 1'b1;
              sch_sector[i]   = c.entry_sector;
              sch_hour[i]     = c.entry_hour;
              sch_minute[i]   = c.entry_minute;
              sch_duration[i] = c.entry_duration;
              occ_count       = occ_count + 3'd1;
              st              = ST_OK;
              slot            = 3'(i);
            end
          end
        end
      end
      OP_DELETE: begin
        if (c.target_slot >= TABLE_SLOTS ||
            (run_phase != PH_IDLE && c.target_slot == run_slot)) begin
          st = ST_BAD_SLOT;
        end else begin
          if (sch_sector[c.target_slot] != 0) begin
            sch_sector[c.target_slot]   = 2'd0;
            sch_hour[c.target_slot]     = 5'd0;
            sch_minute[c.target_slot]   = 6'd0;
            sch_duration[c.target_slot] = 6'd0;
            occ_count = occ_count - 3'd1;
          end
          pending_runs[c.target_slot] = 1'b0;
          slot = c.target_slot;
        end
      end
      default: begin
        pending_runs = '0;
        run_phase    = PH_IDLE;
        run_left     = 6'd0;
        settle_cnt   = 8'd0;
      end
    endcase
    r.valve_mask   = (run_phase != PH_IDLE && sch_sector[run_slot] != 0) ?
                     3'b001 << (sch_sector[run_slot] - 2'd1) : 3'd0;
    r.pump_on      = (run_phase == PH_WATER);
    r.minutes_left = (run_phase != PH_IDLE) ? run_left : 6'd0;
    r.status       = st;
    r.slot_used    = slot;
    r.entry_count  = occ_count;
    r.running      = (run_phase != PH_IDLE);
  endtask

  function automatic void check_field(input string name, input logic [7:0] expv,
                                      input logic [7:0] got);
    if (got !== expv) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, expv, got);
      fail_count++;
    end
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    relay_state_t exp_r;
    if (!rst) begin
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles, stopping", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (done) begin
          if (expected_relays.size() == 0) begin
            $display("%0t ns: done beat with nothing expected", $time);
            fail_count++;
          end else begin
            exp_r = expected_relays.pop_front();
            check_field("valve_mask",   8'(exp_r.valve_mask),   8'(valve_mask));
            check_field("pump_on",      8'(exp_r.pump_on),      8'(pump_on));
            check_field("minutes_left", 8'(exp_r.minutes_left), 8'(minutes_left));
            check_field("status",       8'(exp_r.status),       8'(status));
            check_field("slot_used",    8'(exp_r.slot_used),    8'(slot_used));
            check_field("entry_count",  8'(exp_r.entry_count),  8'(entry_count));
            check_field("running",      8'(exp_r.running),      8'(running));
            beats_checked++;
          end
        end
      end
    end
  end

  task automatic send_cmd(input cmd_t c, input int idle_pct);
    relay_state_t r;
    int           gap;
    start          <= 1'b1;
    op             <= c.op;
    now_hour       <= c.now_hour;
    now_minute     <= c.now_minute;
    entry_sector   <= c.entry_sector;
    entry_hour     <= c.entry_hour;
    entry_minute   <= c.entry_minute;
    entry_duration <= c.entry_duration;
    target_slot    <= c.target_slot;
    do @(posedge clk); while (busy !== 1'b0);
    predict_relays(c, r);
    expected_relays.push_back(r);
    beats_sent++;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_settle(input logic [7:0] v);
    start <= 1'b0;
    while (expected_relays.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    settle_cfg = v;
    cfg_we <= 1'b0;
  endtask

  function automatic cmd_t tick_cmd(input logic [4:0] h, input logic [5:0] m);
    cmd_t c;
    c            = '0;
    c.op         = OP_TICK;
    c.now_hour   = h;
    c.now_minute = m;
    return c;
  endfunction

  function automatic cmd_t add_cmd(input logic [1:0] sec, input logic [4:0] h,
                                   input logic [5:0] m, input logic [5:0] dur);
    cmd_t c;
    c                = '0;
    c.op             = OP_ADD;
    c.entry_sector   = sec;
    c.entry_hour     = h;
    c.entry_minute   = m;
    c.entry_duration = dur;
    return c;
  endfunction

  function automatic cmd_t del_cmd(input logic [2:0] s);
    cmd_t c;
    c             = '0;
    c.op          = OP_DELETE;
    c.target_slot = s;
    return c;
  endfunction

  // mostly sane traffic around a moving wall clock, with some noise
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    int   at;
    c.op             = OP_TICK;
    c.now_hour       = 5'($urandom_range(31));
    c.now_minute     = 6'($urandom_range(63));
    c.entry_sector   = 2'($urandom_range(3));
    c.entry_hour     = 5'($urandom_range(31));
    c.entry_minute   = 6'($urandom_range(63));
    c.entry_duration = 6'($urandom_range(63));
    c.target_slot    = 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 58) begin
      if ($urandom_range(19) != 0) begin
        if ($urandom_range(3) == 0) begin
          wall_m = wall_m + 1;
          if (wall_m == 60) begin
            wall_m = 0;
            wall_h = (wall_h + 1) % 24;
          end
        end
        c.now_hour   = 5'(wall_h);
        c.now_minute = 6'(wall_m);
      end
    end else if (pick < 80) begin
      c.op = OP_ADD;
      if ($urandom_range(9) != 0) c.entry_sector = 2'($urandom_range(1, 3));
      if ($urandom_range(19) != 0) begin
        at = (wall_h * 60 + wall_m + $urandom_range(0, 3)) % 1440;
        c.entry_hour   = 5'(at / 60);
        c.entry_minute = 6'(at % 60);
      end
      if ($urandom_range(7) != 0) c.entry_duration = 6'($urandom_range(3));
    end else if (pick < 97) begin
      c.op = OP_DELETE;
      if ($urandom_range(4) != 0) c.target_slot = 3'($urandom_range(TABLE_SLOTS - 1));
    end else begin
      c.op = OP_CANCEL;
    end
    return c;
  endfunction

  task automatic test_edge_cases();
    cmd_t stop_all;
    stop_all    = '0;
    stop_all.op = OP_CANCEL;
    write_settle(8'd1);
    send_cmd(tick_cmd(5'd0, MINUTE_NONE), 0);  // same as the none-seen marker
    send_cmd(add_cmd(2'd0, 5'd0, 6'd1, 6'd5), 0);
    send_cmd(add_cmd(2'd1, 5'd0, 6'd1, 6'd0), 0);
    send_cmd(add_cmd(2'd2, 5'd0, 6'd1, 6'd1), 0);
    send_cmd(add_cmd(2'd3, 5'd31, 6'd63, 6'd63), 0);
    send_cmd(add_cmd(2'd3, 5'd23, 6'd59, 6'd59), 0);
    send_cmd(add_cmd(2'd1, 5'd0, 6'd2, 6'd2), 0);
    send_cmd(add_cmd(2'd2, 5'd5, 6'd5, 6'd5), 0);
    send_cmd(add_cmd(2'd3, 5'd1, 6'd1, 6'd1), 0);
    send_cmd(del_cmd(3'd6), 0);
    send_cmd(del_cmd(3'd7), 0);
    send_cmd(tick_cmd(5'd0, 6'd1), 0);
    send_cmd(del_cmd(3'd0), 0);
    repeat (3) send_cmd(tick_cmd(5'd0, 6'd1), 0);
    send_cmd(stop_all, 0);
    send_cmd(del_cmd(3'd5), 0);
    send_cmd(del_cmd(3'd5), 0);
    send_cmd(tick_cmd(5'd31, 6'd63), 0);
    send_cmd(tick_cmd(5'd31, 6'd63), 0);
    send_cmd(tick_cmd(5'd23, 6'd59), 0);
    send_cmd(stop_all, 0);
  endtask

  task automatic test_schedule_traffic(input logic [7:0] settle, input int idle_pct,
                                       input int n_items);
    write_settle(settle);
    repeat (n_items) send_cmd(random_cmd(), idle_pct);
  endtask

  initial begin
    wall_h = $urandom_range(23);
    wall_m = $urandom_range(59);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_edge_cases();
    test_schedule_traffic(8'd0, 0, 300);
    test_schedule_traffic(8'd3, 48, 300);
    test_schedule_traffic(8'd255, 22, 250);
    test_schedule_traffic(8'd1, 0, 300);
    test_schedule_traffic(8'($urandom_range(2, 6)), 48, 350);
    start <= 1'b0;
    while (expected_relays.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d commands, checked %0d done beats, %0d watering runs started",
             beats_sent, beats_checked, runs_started);
    $display("Settle values 0, 1, 3, 255 and one random, with and without sender gaps");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
